// ===== design/pra_pkg.sv =====
// ----------------------------------------------------------------------------
// pra_pkg
// Shared types, codes and defaults for the protection region allocator.
// ----------------------------------------------------------------------------
package pra_pkg;

   localparam int DEF_MAX_REGIONS       = 16;
   localparam int DEF_NUM_ENTRIES       = 16;
   localparam int DEF_ENTRIES_PER_GROUP = 8;
   localparam int DEF_PAGE_SHIFT        = 12;

   localparam int ENTRY_W = 5;

   localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [7:0]  ADDR_TOR   = 8'h08;
   localparam logic [7:0]  ADDR_NAPOT = 8'h18;

   localparam logic [2:0] MODE_ALLOC = 3'd0;
   localparam logic [2:0] MODE_FREE  = 3'd1;
   localparam logic [2:0] MODE_SET   = 3'd2;
   localparam logic [2:0] MODE_UNSET = 3'd3;
   localparam logic [2:0] MODE_CHECK = 3'd4;
   localparam logic [2:0] MODE_QUERY = 3'd5;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_SIZE   = 3'd1;
   localparam logic [2:0] ST_OVERLAP    = 3'd2;
   localparam logic [2:0] ST_UNALIGNED  = 3'd3;
   localparam logic [2:0] ST_TOR_IMPOSS = 3'd4;
   localparam logic [2:0] ST_NONE_FREE  = 3'd5;
   localparam logic [2:0] ST_INVALID    = 3'd6;

   localparam logic [1:0] PRI_ANY    = 2'd0;
   localparam logic [1:0] PRI_TOP    = 2'd1;
   localparam logic [1:0] PRI_BOTTOM = 2'd2;
   localparam logic [1:0] PRI_ALT    = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_ALLOC,
      S_READ,
      S_EVAL,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [2:0]  mode;
      logic [63:0] start_req;
      logic [63:0] size;
      logic [1:0]  priority_req;
      logic        shareable;
      logic [3:0]  region_sel;
      logic [2:0]  perm;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  region_out;
      logic [3:0]  entry_index;
      logic [63:0] addr_word;
      logic [63:0] cfg_word;
      logic        overlaps;
      logic [63:0] region_base;
      logic [63:0] region_len;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [63:0]        base;
      logic [63:0]        len;
      logic               napot;
      logic               share;
      logic [ENTRY_W-1:0] entry;
   } rec_type;

endpackage

// ===== design/pmp_region_allocator.sv =====
// ----------------------------------------------------------------------------
// pmp_region_allocator
// Protection region table with used-region and used-entry bitmaps.
// ----------------------------------------------------------------------------
// Allocate with overlap check and check-overlap walk every region through the table
//   memory port before the result; an allocate that fails on overlap ends after the walk.
//   Shareable allocate skips the walk.
// Free, set, unset and query read the region record first, but an invalid region
//   is answered without a read; the second result of an entry pair follows the first.
// One item at a time; a new item is taken once all results transfer.
// Reset clears the bitmaps and the control state; table contents stay undefined.
module pmp_region_allocator import pra_pkg::*; #(
   parameter int MAX_REGIONS       = DEF_MAX_REGIONS,
   parameter int NUM_ENTRIES       = DEF_NUM_ENTRIES,
   parameter int ENTRIES_PER_GROUP = DEF_ENTRIES_PER_GROUP,
   parameter int PAGE_SHIFT        = DEF_PAGE_SHIFT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   localparam int RIW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
   localparam int RCW = $clog2(MAX_REGIONS + 1);
   localparam int EIW = $clog2(NUM_ENTRIES);
   localparam logic [63:0] PMASK = (64'd1 << PAGE_SHIFT) - 64'd1;

   state_type              state_ff, state_in;
   req_type                req_ff, req_in;
   logic [63:0]            end_ff, end_in;
   logic [RCW-1:0]         scan_ff, scan_in;
   logic                   chk_vld_ff, chk_vld_in;
   logic [RIW-1:0]         chk_idx_ff, chk_idx_in;
   logic                   ov_ff, ov_in;
   rsp_type                rsp_ff, rsp_in;
   rsp_type                rsp2_ff, rsp2_in;
   logic                   more_ff, more_in;
   logic [MAX_REGIONS-1:0] rused_ff, rused_in;
   logic [NUM_ENTRIES-1:0] eused_ff, eused_in;

   logic           rd_en, wr_en;
   logic [RIW-1:0] rd_addr, wr_addr;
   rec_type        rd_data, wr_data;

   logic [31:0]    rused_ext;
   logic           sel_valid;
   logic           hit;
   rsp_type        blank;

   pra_table #(
      .DEPTH (MAX_REGIONS),
      .AW    (RIW)
   ) u_table (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   function automatic logic [2:0] grp_slot(input logic [ENTRY_W-1:0] e);
      logic [ENTRY_W-1:0] v;
      v = e;
      for (int k = 0; k < 8; k++) begin
         if (v >= ENTRY_W'(ENTRIES_PER_GROUP)) begin
            v = v - ENTRY_W'(ENTRIES_PER_GROUP);
         end
      end
      return v[2:0];
   endfunction

   assign rused_ext = 32'(rused_ff);
   assign sel_valid = (32'(req_payload.region_sel) < 32'(MAX_REGIONS)) &&
                      rused_ext[req_payload.region_sel];
   assign hit = chk_vld_ff && rused_ff[chk_idx_ff] && !rd_data.share &&
                (rd_data.base < end_ff) &&
                ((rd_data.base + rd_data.len) > req_ff.start_req);

   always_comb begin
      blank      = '0;
      blank.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         chk_vld_ff <= 1'b0;
         more_ff    <= 1'b0;
         rused_ff   <= '0;
         eused_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         chk_vld_ff <= chk_vld_in;
         more_ff    <= more_in;
         rused_ff   <= rused_in;
         eused_ff   <= eused_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      end_ff     <= end_in;
      scan_ff    <= scan_in;
      chk_idx_ff <= chk_idx_in;
      ov_ff      <= ov_in;
      rsp_ff     <= rsp_in;
      rsp2_ff    <= rsp2_in;
   end

   always_comb begin
      logic [1:0]             pri;
      logic                   whole, napot, ovt, pair;
      logic                   r_found, e1_found, ep_found;
      logic [RIW-1:0]         r_idx;
      logic [EIW-1:0]         e1_idx, ep_idx, e_sel, e_idx, e_lo;
      logic [NUM_ENTRIES-1:0] emask, one;
      logic [2:0]             st;
      logic [7:0]             cbyte;
      logic [63:0]            addr;
      rsp_type                r1;
      rsp_type                r2;

      state_in   = state_ff;
      req_in     = req_ff;
      end_in     = end_ff;
      scan_in    = scan_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = scan_ff[RIW-1:0];
      ov_in      = ov_ff;
      rsp_in     = rsp_ff;
      rsp2_in    = rsp2_ff;
      more_in    = more_ff;
      rused_in   = rused_ff;
      eused_in   = eused_ff;
      rd_en      = 1'b0;
      rd_addr    = RIW'(req_ff.region_sel);
      wr_en      = 1'b0;
      req_ready  = (state_ff == S_IDLE);
      rsp_valid  = (state_ff == S_RESP);

      pri = (req_ff.priority_req == PRI_ALT) ? PRI_ANY : req_ff.priority_req;
      whole = (req_ff.size == ALL_ONES) && (req_ff.start_req == 64'd0);
      napot = whole || ((((req_ff.size & (req_ff.size - 64'd1)) == 64'd0)) &&
                        ((req_ff.start_req & (req_ff.size - 64'd1)) == 64'd0));
      r_found = 1'b0;
      r_idx   = '0;
      for (int i = MAX_REGIONS - 1; i >= 0; i--) begin
         if (!rused_ff[i]) begin
            r_found = 1'b1;
            r_idx   = RIW'(i);
         end
      end
      e1_found = 1'b0;
      e1_idx   = '0;
      for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
         if (!eused_ff[i]) begin
            e1_found = 1'b1;
            e1_idx   = EIW'(i);
         end
      end
      ep_found = 1'b0;
      ep_idx   = '0;
      for (int i = NUM_ENTRIES - 2; i >= 0; i--) begin
         if (!eused_ff[i] && !eused_ff[i+1]) begin
            ep_found = 1'b1;
            ep_idx   = EIW'(i);
         end
      end
      one   = NUM_ENTRIES'(1);
      emask = '0;
      e_sel = '0;
      st    = ST_OK;
      if (req_ff.size == 64'd0) begin
         st = ST_BAD_SIZE;
      end else if ((req_ff.size != ALL_ONES && (req_ff.size & PMASK) != 64'd0) ||
                   ((req_ff.start_req & PMASK) != 64'd0)) begin
         st = ST_UNALIGNED;
      end else if (!napot && pri != PRI_ANY &&
                   !(pri == PRI_TOP && req_ff.start_req == 64'd0)) begin
         st = ST_TOR_IMPOSS;
      end else if (!r_found) begin
         st = ST_NONE_FREE;
      end else if (napot) begin
         if (pri == PRI_ANY) begin
            if (!e1_found) begin
               st = ST_NONE_FREE;
            end
            e_sel = e1_idx;
         end else if (pri == PRI_TOP) begin
            if (eused_ff[0]) begin
               st = ST_NONE_FREE;
            end
            e_sel = '0;
         end else begin
            e_sel = EIW'(NUM_ENTRIES - 1);
         end
         emask = one << e_sel;
      end else if (pri == PRI_ANY) begin
         if (!ep_found) begin
            st = ST_NONE_FREE;
         end
         emask = (one | (one << 1)) << ep_idx;
         e_sel = ep_idx + EIW'(1);
      end else begin
         if (eused_ff[0]) begin
            st = ST_NONE_FREE;
         end
         emask = one;
         e_sel = '0;
      end

      wr_addr       = r_idx;
      wr_data.base  = req_ff.start_req;
      wr_data.len   = req_ff.size;
      wr_data.napot = napot;
      wr_data.share = req_ff.shareable;
      wr_data.entry = ENTRY_W'(e_sel);

      e_idx = rd_data.entry[EIW-1:0];
      e_lo  = e_idx - EIW'(1);
      pair  = !rd_data.napot && (rd_data.entry != '0);
      cbyte = (rd_data.napot ? ADDR_NAPOT : ADDR_TOR) | {5'd0, req_ff.perm};
      if (rd_data.base == 64'd0 && rd_data.len == ALL_ONES) begin
         addr = ALL_ONES;
      end else if (rd_data.napot) begin
         addr = (rd_data.base | ((rd_data.len >> 1) - 64'd1)) >> 2;
      end else begin
         addr = (rd_data.base + rd_data.len) >> 2;
      end
      ovt = ov_ff || (end_ff < req_ff.start_req);

      r1 = blank;
      r2 = blank;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in  = req_payload;
               end_in  = req_payload.start_req + req_payload.size;
               ov_in   = 1'b0;
               scan_in = '0;
               more_in = 1'b0;
               case (req_payload.mode)
                  MODE_ALLOC: begin
                     state_in = req_payload.shareable ? S_ALLOC : S_SCAN;
                  end
                  MODE_CHECK: begin
                     state_in = S_SCAN;
                  end
                  MODE_FREE, MODE_SET, MODE_UNSET, MODE_QUERY: begin
                     if (sel_valid) begin
                        state_in = S_READ;
                     end else begin
                        r1        = blank;
                        r1.status = ST_INVALID;
                        rsp_in    = r1;
                        state_in  = S_RESP;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            ov_in = ov_ff || hit;
            if (scan_ff < RCW'(MAX_REGIONS)) begin
               rd_en      = 1'b1;
               rd_addr    = scan_ff[RIW-1:0];
               chk_vld_in = 1'b1;
               scan_in    = scan_ff + RCW'(1);
            end else if (!chk_vld_ff) begin
               if (req_ff.mode == MODE_CHECK) begin
                  r1          = blank;
                  r1.overlaps = ovt;
                  rsp_in      = r1;
                  state_in    = S_RESP;
               end else if (ovt && req_ff.size != 64'd0) begin
                  r1        = blank;
                  r1.status = ST_OVERLAP;
                  rsp_in    = r1;
                  state_in  = S_RESP;
               end else begin
                  state_in = S_ALLOC;
               end
            end
         end
         S_ALLOC: begin
            r1        = blank;
            r1.status = st;
            if (st == ST_OK) begin
               wr_en         = 1'b1;
               rused_in      = rused_ff | (MAX_REGIONS'(1) << r_idx);
               eused_in      = eused_ff | emask;
               r1.region_out = 4'(r_idx);
            end
            rsp_in   = r1;
            state_in = S_RESP;
         end
         S_READ: begin
            rd_en    = 1'b1;
            rd_addr  = RIW'(req_ff.region_sel);
            state_in = S_EVAL;
         end
         S_EVAL: begin
            r1 = blank;
            r2 = blank;
            case (req_ff.mode)
               MODE_FREE: begin
                  emask = one << e_idx;
                  if (pair) begin
                     emask = emask | (one << e_lo);
                  end
                  eused_in = eused_ff & ~emask;
                  rused_in = rused_ff & ~(MAX_REGIONS'(1) << RIW'(req_ff.region_sel));
               end
               MODE_SET, MODE_UNSET: begin
                  r1.entry_index = 4'(rd_data.entry);
                  r1.last        = !pair;
                  r2.entry_index = 4'(rd_data.entry - ENTRY_W'(1));
                  if (req_ff.mode == MODE_SET) begin
                     r1.addr_word = addr;
                     r1.cfg_word  = 64'(cbyte) << {grp_slot(rd_data.entry), 3'b000};
                     r2.addr_word = rd_data.base >> 2;
                  end
                  more_in = pair;
               end
               MODE_QUERY: begin
                  r1.region_base = rd_data.base;
                  r1.region_len  = rd_data.len;
               end
               default: begin
                  r1 = blank;
               end
            endcase
            rsp_in   = r1;
            rsp2_in  = r2;
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) begin
               if (more_ff) begin
                  rsp_in  = rsp2_ff;
                  more_in = 1'b0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_no_accept_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input taken while a result is pending");

   a_maps_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_ALLOC && state_ff != S_EVAL) |=>
         ($stable(rused_ff) && $stable(eused_ff)))
      else $error("bitmaps changed outside update states");

   a_pair_pending: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_payload.last) |-> more_ff)
      else $error("non-final result without a second result queued");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (scan_ff <= RCW'(MAX_REGIONS)))
      else $error("region walk ran past the table");
`endif

endmodule

// ===== design/pra_table.sv =====
// ----------------------------------------------------------------------------
// pra_table
// Region record memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pra_table import pra_pkg::*; #(
   parameter int DEPTH = DEF_MAX_REGIONS,
   parameter int AW    = 4
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output rec_type       rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  rec_type       wr_data
);

   rec_type mem [DEPTH];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the protection region allocator: a table of directed
// requests, then random region lifecycles, checked against a behavioral model.
// ----------------------------------------------------------------------------
module testbench;
   import pra_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_payload;

   pmp_region_allocator uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload)
   );

   localparam int NREG = DEF_MAX_REGIONS;
   localparam int NENT = DEF_NUM_ENTRIES;

   logic [63:0] reg_base [NREG];
   logic [63:0] reg_len [NREG];
   logic        reg_napot [NREG];
   logic        reg_share [NREG];
   logic [3:0]  reg_entry [NREG];
   logic [15:0] region_map;
   logic [15:0] entry_map;

   rsp_type pending_rsps[$];
   int      mismatch_count;
   int      send_idle_pct;
   int      recv_idle_pct;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic rsp_type blank_rsp();
      rsp_type r;
      r = '0;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic bit region_hits(logic [63:0] s, logic [63:0] sz);
      logic [63:0] e;
      bit hit;
      e = s + sz;
      hit = 0;
      if (e < s) return 1;
      for (int i = 0; i < NREG; i++)
         if (region_map[i] && !reg_share[i] && reg_base[i] < e && reg_base[i] + reg_len[i] > s)
            hit = 1;
      return hit;
   endfunction

   function automatic logic [2:0] try_allocate(req_type q, output logic [3:0] rg);
      logic [63:0] pmask;
      logic [1:0]  pri;
      bit napot;
      int r, e;
      pmask = (64'd1 << DEF_PAGE_SHIFT) - 1;
      pri = (q.priority_req == PRI_ALT) ? PRI_ANY : q.priority_req;
      rg = 0;
      r = -1;
      e = -1;
      if (q.size == 0) return ST_BAD_SIZE;
      if (!q.shareable && region_hits(q.start_req, q.size)) return ST_OVERLAP;
      if ((q.size != ALL_ONES && (q.size & pmask) != 0) || (q.start_req & pmask) != 0)
         return ST_UNALIGNED;
      napot = (q.size == ALL_ONES && q.start_req == 0) ||
              ((q.size & (q.size - 1)) == 0 && (q.start_req & (q.size - 1)) == 0);
      if (!napot && pri != PRI_ANY && (pri != PRI_TOP || q.start_req != 0))
         return ST_TOR_IMPOSS;
      for (int i = NREG - 1; i >= 0; i--) if (!region_map[i]) r = i;
      if (r < 0) return ST_NONE_FREE;
      if (napot) begin
         if (pri == PRI_ANY) begin
            for (int i = NENT - 1; i >= 0; i--) if (!entry_map[i]) e = i;
            if (e < 0) return ST_NONE_FREE;
         end else if (pri == PRI_TOP) begin
            if (entry_map[0]) return ST_NONE_FREE;
            e = 0;
         end else begin
            e = NENT - 1;
         end
         entry_map[e] = 1'b1;
      end else if (pri == PRI_ANY) begin
         for (int i = NENT - 2; i >= 0; i--) if (!entry_map[i] && !entry_map[i+1]) e = i;
         if (e < 0) return ST_NONE_FREE;
         entry_map[e] = 1'b1;
         entry_map[e+1] = 1'b1;
         e = e + 1;
      end else begin
         if (entry_map[0]) return ST_NONE_FREE;
         e = 0;
         entry_map[0] = 1'b1;
      end
      reg_base[r] = q.start_req;
      reg_len[r] = q.size;
      reg_napot[r] = napot;
      reg_share[r] = q.shareable;
      reg_entry[r] = 4'(e);
      region_map[r] = 1'b1;
      rg = 4'(r);
      return ST_OK;
   endfunction

   task automatic predict_allocator(req_type q);
      rsp_type r, r2;
      logic [3:0] s, e;
      bit pair;
      r = blank_rsp();
      s = q.region_sel;
      case (q.mode)
         MODE_ALLOC: begin
            r.status = try_allocate(q, r.region_out);
            pending_rsps.push_back(r);
         end
         MODE_CHECK: begin
            r.overlaps = region_hits(q.start_req, q.size);
            pending_rsps.push_back(r);
         end
         MODE_FREE, MODE_SET, MODE_UNSET, MODE_QUERY: begin
            if (!region_map[s]) begin
               r.status = ST_INVALID;
               pending_rsps.push_back(r);
            end else if (q.mode == MODE_FREE) begin
               e = reg_entry[s];
               entry_map[e] = 1'b0;
               if (!reg_napot[s] && e > 0) entry_map[e-4'd1] = 1'b0;
               region_map[s] = 1'b0;
               pending_rsps.push_back(r);
            end else if (q.mode == MODE_QUERY) begin
               r.region_base = reg_base[s];
               r.region_len = reg_len[s];
               pending_rsps.push_back(r);
            end else begin
               e = reg_entry[s];
               pair = !reg_napot[s] && e > 0;
               r.entry_index = e;
               r.last = !pair;
               if (q.mode == MODE_SET) begin
                  if (reg_base[s] == 0 && reg_len[s] == ALL_ONES) r.addr_word = ALL_ONES;
                  else if (reg_napot[s])
                     r.addr_word = (reg_base[s] | (reg_len[s] / 2 - 1)) >> 2;
                  else r.addr_word = (reg_base[s] + reg_len[s]) >> 2;
                  r.cfg_word = 64'({reg_napot[s] ? ADDR_NAPOT : ADDR_TOR} | 8'(q.perm))
                               << (8 * (e % DEF_ENTRIES_PER_GROUP));
               end
               pending_rsps.push_back(r);
               if (pair) begin
                  r2 = blank_rsp();
                  r2.entry_index = e - 4'd1;
                  if (q.mode == MODE_SET) r2.addr_word = reg_base[s] >> 2;
                  pending_rsps.push_back(r2);
               end
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("unexpected transfer: %p", rsp_payload);
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_payload !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected %p actual %p", want, rsp_payload);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
   end

   task automatic send_item(req_type q);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_allocator(q);
   endtask

   function automatic req_type make_req(logic [2:0] m, logic [63:0] s, logic [63:0] z,
                                        logic [1:0] p, logic sh, logic [3:0] rs,
                                        logic [2:0] pm);
      req_type q;
      q.mode = m; q.start_req = s; q.size = z; q.priority_req = p;
      q.shareable = sh; q.region_sel = rs; q.perm = pm;
      return q;
   endfunction

   function automatic req_type random_req();
      req_type q;
      int k;
      q = '0;
      q.perm = 3'($urandom);
      q.priority_req = 2'($urandom);
      q.shareable = ($urandom_range(3, 0) == 0);
      q.region_sel = ($urandom_range(3, 0) == 0) ? 4'($urandom) : 4'($urandom_range(3, 0));
      k = $urandom_range(99, 0);
      q.mode = (k < 30) ? MODE_ALLOC : (k < 45) ? MODE_FREE : (k < 65) ? MODE_SET :
               (k < 75) ? MODE_UNSET : (k < 85) ? MODE_CHECK : (k < 97) ? MODE_QUERY :
               3'($urandom_range(7, 6));
      k = $urandom_range(9, 0);
      if (k < 4) begin
         q.size = 64'd1 << $urandom_range(24, 12);
         q.start_req = (64'($urandom_range(255, 0)) << 20) & ~(q.size - 1);
      end else if (k < 7) begin
         q.size = 64'($urandom_range(64, 1)) << 12;
         q.start_req = ($urandom_range(1, 0) ? 64'd0 : 64'($urandom_range(4095, 0)) << 12);
      end else if (k < 8) begin
         q.size = ($urandom_range(1, 0)) ? ALL_ONES : {$urandom, $urandom};
         q.start_req = ($urandom_range(1, 0)) ? 64'd0 : {$urandom, $urandom};
      end else begin
         q.size = {$urandom, $urandom};
         q.start_req = {$urandom, $urandom};
      end
      return q;
   endfunction

   req_type     stim_rows [$];
   logic        row_known [$];
   rsp_type     row_rsp [$];

   task automatic add_row(req_type q, bit known, rsp_type r);
      stim_rows.push_back(q);
      row_known.push_back(known);
      row_rsp.push_back(r);
   endtask

   initial begin
      rsp_type ok, inv, rr;
      clock = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      mismatch_count = 0;
      send_idle_pct = 30;
      recv_idle_pct = 81;
      region_map = '0;
      entry_map = '0;
      ok = blank_rsp();
      inv = blank_rsp();
      inv.status = ST_INVALID;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      add_row(make_req(MODE_QUERY, 0, 0, PRI_ANY, 0, 4'd15, 0), 1, inv);
      add_row(make_req(MODE_FREE, 0, 0, PRI_ANY, 0, 4'd0, 0), 1, inv);
      add_row(make_req(MODE_SET, 0, 0, PRI_ANY, 0, 4'd3, 7), 1, inv);
      add_row(make_req(MODE_UNSET, 0, 0, PRI_ANY, 0, 4'd9, 0), 1, inv);
      rr = ok; rr.status = ST_BAD_SIZE;
      add_row(make_req(MODE_ALLOC, 0, 0, PRI_ANY, 0, 0, 0), 1, rr);
      rr = ok; rr.status = ST_UNALIGNED;
      add_row(make_req(MODE_ALLOC, 64'h10, 64'h1000, PRI_ANY, 0, 0, 0), 1, rr);
      rr = ok; rr.status = ST_TOR_IMPOSS;
      add_row(make_req(MODE_ALLOC, 64'h1000, 64'h3000, PRI_BOTTOM, 0, 0, 0), 1, rr);
      rr = ok; rr.status = ST_OVERLAP;
      add_row(make_req(MODE_ALLOC, ALL_ONES - 64'hFFF, 64'h2000, PRI_ANY, 0, 0, 0), 1, rr);
      add_row(make_req(MODE_ALLOC, 0, ALL_ONES, PRI_ANY, 1, 0, 0), 1, ok);
      add_row(make_req(MODE_SET, 0, 0, PRI_ANY, 0, 0, 7), 0, ok);
      add_row(make_req(MODE_ALLOC, 64'h10000, 64'h3000, PRI_ANY, 0, 0, 0), 0, ok);
      add_row(make_req(MODE_SET, 0, 0, PRI_ANY, 0, 1, 5), 0, ok);
      add_row(make_req(MODE_UNSET, 0, 0, PRI_ANY, 0, 1, 0), 0, ok);
      add_row(make_req(MODE_ALLOC, 0, 64'h5000, PRI_TOP, 0, 0, 0), 0, ok);
      add_row(make_req(MODE_ALLOC, 64'h100000, 64'h1000, PRI_BOTTOM, 0, 0, 0), 0, ok);
      add_row(make_req(MODE_ALLOC, 64'h200000, 64'h1000, PRI_ALT, 0, 0, 0), 0, ok);
      add_row(make_req(MODE_SET, 0, 0, PRI_ANY, 0, 3, 3), 0, ok);
      add_row(make_req(MODE_CHECK, 64'h11000, 64'h100, 0, 0, 0, 0), 0, ok);
      add_row(make_req(MODE_CHECK, ALL_ONES, 64'd2, 0, 0, 0, 0), 0, ok);
      add_row(make_req(MODE_QUERY, 0, 0, 0, 0, 1, 0), 0, ok);
      add_row(make_req(3'd6, ALL_ONES, ALL_ONES, 2'd3, 1, 4'd15, 7), 0, ok);
      add_row(make_req(3'd7, 0, 0, 0, 0, 0, 0), 0, ok);
      add_row(make_req(MODE_FREE, 0, 0, 0, 0, 1, 0), 0, ok);
      add_row(make_req(MODE_FREE, 0, 0, 0, 0, 0, 0), 0, ok);

      foreach (stim_rows[i]) begin
         send_item(stim_rows[i]);
         if (row_known[i] && pending_rsps.size() > 0 &&
             pending_rsps[pending_rsps.size()-1] !== row_rsp[i]) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("table row %0d: expected %p model %p", i, row_rsp[i],
                        pending_rsps[pending_rsps.size()-1]);
         end
      end

      for (int n = 0; n < 1100; n++) begin
         if (n == 370) begin
            send_idle_pct = 81;
            recv_idle_pct = 30;
         end
         if (n == 740) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (n == 500) begin
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_rsps.size() != 0) @(posedge clock);
         end
         send_item(random_req());
      end

      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

// ===== pmp_region_allocator.f =====
design/pra_pkg.sv
design/pra_table.sv
design/pmp_region_allocator.sv
dv/testbench.sv
